/* rtl/fbc64_pkg.sv */
`default_nettype none
package fbc64_pkg;

  localparam int ROUNDS = 32;
  localparam int KEY_WORDS = 8;
  localparam int ROT_LEFT = 11;

  // Rounds that walk the key words forward before turning to reverse order.
  localparam logic [5:0] FWD_ROUNDS_ENC = 6'd24;
  localparam logic [5:0] FWD_ROUNDS_DEC = 6'd8;

  // Configuration register indexes.
  localparam logic [2:0] REG_KEY_01   = 3'd0;
  localparam logic [2:0] REG_KEY_23   = 3'd1;
  localparam logic [2:0] REG_KEY_45   = 3'd2;
  localparam logic [2:0] REG_KEY_67   = 3'd3;
  localparam logic [2:0] REG_ENC_MODE = 3'd4;

  typedef struct packed {
    logic [31:0] first_half;
    logic [31:0] second_half;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_first_half;
    logic [31:0] result_second_half;
  } out_item_t;

  // Working halves carried from cell to cell.
  typedef struct packed {
    logic [31:0] n1;
    logic [31:0] n2;
  } halves_t;

  // Substitution rows, one per nibble position.
  localparam logic [3:0] SBOX [8][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15}
  };

  function automatic logic [31:0] substitute(input logic [31:0] v);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[4*i +: 4] = SBOX[i][v[4*i +: 4]];
    end
    return r;
  endfunction

  // Round function: add key, substitute, rotate left.
  function automatic logic [31:0] round_fn(input logic [31:0] half, input logic [31:0] k);
    logic [31:0] s;
    s = substitute(half + k);
    return {s[31-ROT_LEFT:0], s[31:32-ROT_LEFT]};
  endfunction

  // Key word used in a given round for the selected direction.
  function automatic logic [2:0] key_index(input logic [4:0] rnd, input logic enc);
    logic [5:0] fwd;
    fwd = enc ? FWD_ROUNDS_ENC : FWD_ROUNDS_DEC;
    if ({1'b0, rnd} < fwd) begin
      return rnd[2:0];
    end
    return 3'd7 - rnd[2:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/fbc64_round_cell.sv */
`default_nettype none
module fbc64_round_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [31:0]       key,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire fbc64_pkg::halves_t up_data,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output fbc64_pkg::halves_t     dn_data
);

  logic               valid;
  fbc64_pkg::halves_t data;

  // Take a new item whenever the held one is empty or leaving.
  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data.n1 <= fbc64_pkg::round_fn(up_data.n1, key) ^ up_data.n2;
      data.n2 <= up_data.n1;
    end
  end

endmodule
`default_nettype wire

/* rtl/feistel_block_cipher_64_unit.sv */
`default_nettype none
// 64-bit Feistel block cipher, 32 rounds, codebook mode.
//
// Input channel (in_valid/in_ready/in_data) takes one block as two 32-bit
// halves per transfer; output channel (out_valid/out_ready/out_data) returns
// the transformed block. Key words and direction come through the write port
// (cfg_we/cfg_index/cfg_wdata); write them only while no block is in flight.
//
// The datapath is a chain of 32 round cells, one round per cell, each cell a
// register stage with its own valid bit. A block passes through every cell
// register in order before it is presented on the output. Blocks may enter
// every cycle while the output is not stalled, so sustained throughput is one
// block per cycle; latency is set by the depth of the cell chain.
//
// Reset clears every valid bit, all key words to zero and selects encryption.
// When the receiver stalls, the last cell holds its result and the stall
// ripples back only through occupied cells: empty cells keep accepting, so
// the input side stays ready until the chain is full.
module feistel_block_cipher_64_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [63:0]          cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire fbc64_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output fbc64_pkg::out_item_t      out_data
);

  localparam int R = fbc64_pkg::ROUNDS;

  logic [31:0] key_word [fbc64_pkg::KEY_WORDS];
  logic        encrypt_mode;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fbc64_pkg::KEY_WORDS; i++) begin
        key_word[i] <= '0;
      end
      encrypt_mode <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        fbc64_pkg::REG_KEY_01: begin
          key_word[0] <= cfg_wdata[31:0];
          key_word[1] <= cfg_wdata[63:32];
        end
        fbc64_pkg::REG_KEY_23: begin
          key_word[2] <= cfg_wdata[31:0];
          key_word[3] <= cfg_wdata[63:32];
        end
        fbc64_pkg::REG_KEY_45: begin
          key_word[4] <= cfg_wdata[31:0];
          key_word[5] <= cfg_wdata[63:32];
        end
        fbc64_pkg::REG_KEY_67: begin
          key_word[6] <= cfg_wdata[31:0];
          key_word[7] <= cfg_wdata[63:32];
        end
        fbc64_pkg::REG_ENC_MODE: begin
          encrypt_mode <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Links between cells: link 0 is the input, link R the last cell.
  logic               link_valid [R+1];
  logic               link_ready [R+1];
  fbc64_pkg::halves_t link_data  [R+1];

  assign link_valid[0]   = in_valid;
  assign in_ready        = link_ready[0];
  assign link_data[0].n1 = in_data.first_half;
  assign link_data[0].n2 = in_data.second_half;

  for (genvar r = 0; r < R; r++) begin : g_round
    logic [31:0] round_key;

    // Key schedule is fixed per cell position and direction.
    assign round_key = key_word[fbc64_pkg::key_index(5'(r), encrypt_mode)];

    fbc64_round_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .key      (round_key),
      .up_valid (link_valid[r]),
      .up_ready (link_ready[r]),
      .up_data  (link_data[r]),
      .dn_valid (link_valid[r+1]),
      .dn_ready (link_ready[r+1]),
      .dn_data  (link_data[r+1])
    );
  end

  // Every cell swaps halves; the final round does not, so undo it here.
  assign out_valid                   = link_valid[R];
  assign link_ready[R]               = out_ready;
  assign out_data.result_first_half  = link_data[R].n2;
  assign out_data.result_second_half = link_data[R].n1;

endmodule
`default_nettype wire

/* rtl/fbc64_checker.sv */
`default_nettype none
module fbc64_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire fbc64_pkg::in_item_t  in_data,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire fbc64_pkg::out_item_t out_data
);

  // Held result stays presented until transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // An offered block stays on the input until transferred.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input offer withdrawn or changed while stalled");

  // Reset empties the whole chain.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

  // With the last stage free, the input side must be open.
  a_in_open: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input blocked although the chain can advance");

endmodule

bind feistel_block_cipher_64_unit fbc64_checker u_fbc64_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
